>>> hdl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared widths, constants and handshake types of the B-spline curve sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int SCW        = 16;
  localparam int CCW        = 13;
  localparam int ACW        = 12;
  localparam int CW_DEF     = 32;
  localparam int MAXSEG_DEF = 64;
  localparam int VFB        = 16;
  localparam int VW         = VFB + 1;
  localparam int WFB        = 3 * VFB;
  localparam int WW         = WFB + 3;
  localparam int WL         = 26;
  localparam int DVW        = VFB + 2;

  localparam logic [SCW-1:0] SC_RESET = SCW'(64);
  localparam logic [CCW-1:0] CC_RESET = CCW'(8);
  localparam logic [SCW-1:0] SC_MIN   = SCW'(5);
  localparam logic [CCW-1:0] CC_MIN   = CCW'(5);
  localparam logic [CCW-1:0] CC_MAX   = CCW'(4096);
  localparam logic [CCW-1:0] LEAD_PTS = CCW'(3);

  localparam logic [VW-1:0]  V_HALF   = VW'(1) << (VFB - 1);
  localparam logic [VW-1:0]  V_ONE    = VW'(1) << VFB;
  localparam logic [DVW-1:0] STEP_NUM = DVW'(1) << (VFB + 1);

  typedef enum logic [0:0] {
    CFG_SAMPLE_COUNT  = 1'b0,
    CFG_CONTROL_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] dividend;
    logic [CCW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [DVW-1:0] quot;
    logic [CCW-1:0] rem;
  } div_rsp_t;

endpackage

>>> hdl/cbs_div.sv
// ----------------------------------------------------------------------------
// cbs_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbs_pkg::div_req_t req_i,
  output cbs_pkg::div_rsp_t rsp_o
);

  localparam int CNTW = $clog2(cbs_pkg::DVW + 1);

  logic                      busy_q;
  logic                      done_q;
  logic [CNTW-1:0]           cnt_q;
  logic [cbs_pkg::DVW-1:0]   num_q;
  logic [cbs_pkg::CCW-1:0]   rem_q;
  logic [cbs_pkg::CCW-1:0]   den_q;
  logic [cbs_pkg::CCW:0]     rem_sh;
  logic                      ge;
  logic [cbs_pkg::CCW:0]     rem_sub;

  assign rem_sh  = {rem_q, num_q[cbs_pkg::DVW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(cbs_pkg::DVW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      num_q <= {num_q[cbs_pkg::DVW-2:0], ge};
      rem_q <= ge ? rem_sub[cbs_pkg::CCW-1:0] : rem_sh[cbs_pkg::CCW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/cbs_basis.sv
// ----------------------------------------------------------------------------
// cbs_basis
// Three-stage pipeline forming the four uniform cubic basis weights of v.
// ----------------------------------------------------------------------------
module cbs_basis (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [cbs_pkg::VW-1:0]              v_i,
  output logic [3:0][cbs_pkg::WW-1:0]         w_o
);

  localparam int PW = 2 * cbs_pkg::VW;
  localparam int XW = cbs_pkg::WW + 2;

  logic [cbs_pkg::VW-1:0] v1_q, u1_q, v2b_q;
  logic [PW-1:0]          vv_q, uu_q, vvb_q;
  logic [XW-1:0]          v3_q, u3_q;
  logic [3:0][cbs_pkg::WW-1:0] w_q;
  logic [XW-1:0]          w1_x, w2_x;
  logic [cbs_pkg::VW-1:0] u_in;

  assign u_in = cbs_pkg::V_ONE - v_i;

  always_comb begin
    w1_x = XW'(3) * v3_q + (XW'(4) << cbs_pkg::WFB)
         - ((XW'(6) * XW'(vvb_q)) << cbs_pkg::VFB);
    w2_x = ((XW'(3) * XW'(vvb_q)) << cbs_pkg::VFB)
         + ((XW'(3) * XW'(v2b_q)) << (2 * cbs_pkg::VFB))
         + (XW'(1) << cbs_pkg::WFB) - XW'(3) * v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q   <= v_i;
      u1_q   <= u_in;
      vv_q   <= v_i * v_i;
      uu_q   <= u_in * u_in;
      v3_q   <= XW'(vv_q * v1_q);
      u3_q   <= XW'(uu_q * u1_q);
      vvb_q  <= vv_q;
      v2b_q  <= v1_q;
      w_q[0] <= u3_q[cbs_pkg::WW-1:0];
      w_q[1] <= w1_x[cbs_pkg::WW-1:0];
      w_q[2] <= w2_x[cbs_pkg::WW-1:0];
      w_q[3] <= v3_q[cbs_pkg::WW-1:0];
    end
  end

  assign w_o = w_q;

endmodule

>>> hdl/cbs_lane.sv
// ----------------------------------------------------------------------------
// cbs_lane
// One product lane: a control coordinate in offset binary times one weight,
// split into two partial products and recombined in the next stage.
// ----------------------------------------------------------------------------
module cbs_lane #(
  parameter int COORD_WIDTH = cbs_pkg::CW_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [COORD_WIDTH-1:0]                 p_i,
  input  logic [cbs_pkg::WW-1:0]                 w_i,
  output logic [COORD_WIDTH+cbs_pkg::WW-1:0]     term_o
);

  localparam int TW = COORD_WIDTH + cbs_pkg::WW;
  localparam int HW = cbs_pkg::WW - cbs_pkg::WL;

  logic [COORD_WIDTH-1:0]              pu;
  logic [COORD_WIDTH+cbs_pkg::WL-1:0]  lo_q;
  logic [COORD_WIDTH+HW-1:0]           hi_q;
  logic [TW-1:0]                       term_q;

  assign pu = p_i ^ (COORD_WIDTH'(1) << (COORD_WIDTH - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q   <= pu * w_i[cbs_pkg::WL-1:0];
      hi_q   <= pu * w_i[cbs_pkg::WW-1:cbs_pkg::WL];
      term_q <= (TW'(hi_q) << cbs_pkg::WL) + TW'(lo_q);
    end
  end

  assign term_o = term_q;

endmodule

>>> hdl/cbs_merge.sv
// ----------------------------------------------------------------------------
// cbs_merge
// Sums the four lane products with the rounding offset, divides by six
// through a split reciprocal, saturates and returns to two's complement.
// ----------------------------------------------------------------------------
module cbs_merge #(
  parameter int COORD_WIDTH = cbs_pkg::CW_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic [3:0][COORD_WIDTH+cbs_pkg::WW-1:0]   term_i,
  output logic [COORD_WIDTH-1:0]                    res_o
);

  localparam int TW  = COORD_WIDTH + cbs_pkg::WW;
  localparam int XW  = COORD_WIDTH + 2;
  localparam int H   = ((COORD_WIDTH + 5) / 4) * 2;
  localparam int AW  = XW - H;
  localparam int K   = H + 3;
  localparam int MW  = H + 2;
  localparam logic [MW-1:0] MREC = MW'(((64'd1 << K) + 64'd2) / 64'd3);
  localparam logic [H-1:0]  K3   = H'(((64'd1 << H) - 64'd1) / 64'd3);
  localparam logic [TW-1:0] RND  = TW'(3) << cbs_pkg::WFB;
  localparam logic [XW-1:0] SATV = XW'({COORD_WIDTH{1'b1}});

  logic [TW-1:0]          s01_q, s23_q;
  logic [TW-1:0]          acc;
  logic [XW-1:0]          x_q;
  logic [XW-1:0]          ak_q, ak2_q;
  logic [H:0]             y_q;
  logic [2*H+2:0]         yp;
  logic [H-1:0]           yq_q;
  logic [XW-1:0]          t;
  logic [COORD_WIDTH-1:0] res_q;
  logic [COORD_WIDTH-1:0] sat;

  assign acc = s01_q + s23_q + RND;
  assign yp  = y_q * MREC;
  assign t   = ak2_q + XW'(yq_q);
  assign sat = (t > SATV) ? {COORD_WIDTH{1'b1}} : t[COORD_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s01_q <= term_i[0] + term_i[1];
      s23_q <= term_i[2] + term_i[3];
      x_q   <= acc[TW-1:cbs_pkg::WFB+1];
      ak_q  <= XW'(x_q[XW-1:H] * K3);
      y_q   <= (H+1)'(x_q[XW-1:H]) + (H+1)'(x_q[H-1:0]);
      ak2_q <= ak_q;
      yq_q  <= yp[K +: H];
      res_q <= sat ^ (COORD_WIDTH'(1) << (COORD_WIDTH - 1));
    end
  end

  assign res_o = res_q;

endmodule

>>> hdl/cubic_bspline_curve_sampler.sv
// ----------------------------------------------------------------------------
// cubic_bspline_curve_sampler
// Uniform cubic B-spline sampler over a stream of 2-D control points.
// ----------------------------------------------------------------------------
// Each accepted control point first runs a divide of the sample count by the
// segment count, which holds the point input stalled. A point that closes a
// segment of L > 1 samples then passes through a set-up state and a second
// divide for the sample spacing. After that the segment's samples leave at one
// per cycle while the output is not stalled, through an 11-stage datapath of
// basis weights, eight product lanes and a merge. The next point is accepted
// once the last sample has reached the lanes. A point that closes a
// single-sample segment skips the second divide, any other point runs only
// the first divide, and a point under a bad configuration skips both divides,
// unless only the segment length is too long, which is found after the first
// divide. Both divides use the shared divider.
// ----------------------------------------------------------------------------
module cubic_bspline_curve_sampler #(
  parameter int MAX_SEGMENT_SAMPLES = cbs_pkg::MAXSEG_DEF,
  parameter int COORD_WIDTH         = cbs_pkg::CW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [cbs_pkg::SCW-1:0]       cfg_data_i,
  input  logic                          point_valid_i,
  output logic                          point_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic                          first_point_i,
  output logic                          sample_valid_o,
  input  logic                          sample_stall_i,
  output logic signed [COORD_WIDTH-1:0] sample_x_o,
  output logic signed [COORD_WIDTH-1:0] sample_y_o,
  output logic                          segment_end_o,
  output logic                          curve_end_o,
  output logic                          config_error_o
);

  localparam int LW  = $clog2(MAX_SEGMENT_SAMPLES + 2);
  localparam int DDW = $clog2(2 * MAX_SEGMENT_SAMPLES + 1);
  localparam int LAT = 10;
  localparam int TW  = COORD_WIDTH + cbs_pkg::WW;
  localparam int CCW = cbs_pkg::CCW;
  localparam int DVW = cbs_pkg::DVW;
  localparam int VW  = cbs_pkg::VW;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DIV_SEG  = 6'b000010,
    ST_PREP     = 6'b000100,
    ST_DIV_STEP = 6'b001000,
    ST_EMIT     = 6'b010000,
    ST_ERR      = 6'b100000
  } state_e;

  typedef struct packed {
    logic valid;
    logic seg_end;
    logic curve_end;
    logic err;
  } tag_t;

  state_e                   state_q, state_d;
  logic [cbs_pkg::SCW-1:0]  sc_q;
  logic [CCW-1:0]           cc_q;
  logic [COORD_WIDTH-1:0]   win_x_q [3];
  logic [COORD_WIDTH-1:0]   win_y_q [3];
  logic [COORD_WIDTH-1:0]   win_x_d [3];
  logic [COORD_WIDTH-1:0]   win_y_d [3];
  logic [CCW-1:0]           ps_q, ps_d;
  logic [cbs_pkg::ACW-1:0]  spread_q, spread_d;
  logic [COORD_WIDTH-1:0]   px_q, py_q;
  logic                     first_q;
  logic [COORD_WIDTH-1:0]   cx_q [4];
  logic [COORD_WIDTH-1:0]   cy_q [4];
  logic                     cap;
  logic                     last_seg_q, last_seg_d;
  logic [LW-1:0]            len_q, len_d;
  logic [LW-1:0]            j_q, j_d;
  logic [VW-1:0]            v_q, v_d;
  logic [VW-1:0]            dq_q, dq_d;
  logic [DDW-1:0]           dr_q, dr_d;
  logic [DDW-1:0]           dd_q, dd_d;
  logic [DDW-1:0]           vrem_q, vrem_d;
  tag_t                     tok_q, tok_d;
  logic [VW-1:0]            tok_v_q, tok_v_d;
  tag_t                     tag_q [LAT];
  logic                     adv;
  logic                     pipe_busy;
  logic                     accept;
  logic                     prebad;
  cbs_pkg::div_req_t        div_req;
  cbs_pkg::div_rsp_t        div_rsp;
  logic [CCW-1:0]           n;
  logic [DVW:0]             longest;
  logic [CCW-1:0]           ps_eff;
  logic [cbs_pkg::ACW-1:0]  acc0;
  logic [CCW-1:0]           acc;
  logic                     acc_ge;
  logic [CCW-1:0]           acc_new;
  logic                     seg_end;
  logic                     j_last;
  logic [DDW:0]             vsum;
  logic                     vcarry;
  logic [3:0][cbs_pkg::WW-1:0] w;
  logic [3:0][TW-1:0]       term_x, term_y;
  logic [COORD_WIDTH-1:0]   res_x, res_y;

  assign adv       = !(tag_q[LAT-1].valid && sample_stall_i);
  assign pipe_busy = tok_q.valid || tag_q[0].valid || tag_q[1].valid || tag_q[2].valid;
  assign point_stall_o = (state_q != ST_IDLE) || pipe_busy;
  assign accept    = point_valid_i && !point_stall_o;

  assign prebad = (sc_q < cbs_pkg::SC_MIN) || (cc_q < cbs_pkg::CC_MIN)
               || (cc_q > cbs_pkg::CC_MAX) || (sc_q < cbs_pkg::SCW'(cc_q));

  assign n       = cc_q - cbs_pkg::LEAD_PTS;
  assign longest = (DVW+1)'(div_rsp.quot) + (DVW+1)'(div_rsp.rem != '0);
  assign ps_eff  = first_q ? '0 : ps_q;
  assign acc0    = first_q ? '0 : spread_q;
  assign acc     = CCW'(acc0) + div_rsp.rem;
  assign acc_ge  = acc >= n;
  assign acc_new = acc_ge ? acc - n : acc;

  assign seg_end = (j_q + LW'(1)) == len_q;
  assign j_last  = seg_end || (j_q == LW'(MAX_SEGMENT_SAMPLES - 1));
  assign vsum    = {1'b0, vrem_q} + {1'b0, dr_q};
  assign vcarry  = vsum >= {1'b0, dd_q};

  always_comb begin
    state_d    = state_q;
    ps_d       = ps_q;
    spread_d   = spread_q;
    last_seg_d = last_seg_q;
    len_d      = len_q;
    j_d        = j_q;
    v_d        = v_q;
    dq_d       = dq_q;
    dr_d       = dr_q;
    dd_d       = dd_q;
    vrem_d     = vrem_q;
    cap        = 1'b0;
    for (int i = 0; i < 3; i++) begin
      win_x_d[i] = win_x_q[i];
      win_y_d[i] = win_y_q[i];
    end
    tok_d            = '0;
    tok_v_d          = v_q;
    div_req.start    = 1'b0;
    div_req.dividend = DVW'(sc_q);
    div_req.divisor  = n;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (prebad) begin
            state_d = ST_ERR;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_DIV_SEG;
          end
        end
      end
      ST_DIV_SEG: begin
        if (div_rsp.done) begin
          if (longest > (DVW+1)'(MAX_SEGMENT_SAMPLES)) begin
            state_d = ST_ERR;
          end else if (ps_eff >= cc_q) begin
            state_d = ST_IDLE;
          end else begin
            win_x_d[0] = first_q ? '0 : win_x_q[1];
            win_x_d[1] = first_q ? '0 : win_x_q[2];
            win_x_d[2] = px_q;
            win_y_d[0] = first_q ? '0 : win_y_q[1];
            win_y_d[1] = first_q ? '0 : win_y_q[2];
            win_y_d[2] = py_q;
            ps_d       = ps_eff + CCW'(1);
            spread_d   = acc0;
            if (ps_eff < cbs_pkg::LEAD_PTS) begin
              state_d = ST_IDLE;
            end else begin
              cap        = 1'b1;
              spread_d   = acc_new[cbs_pkg::ACW-1:0];
              len_d      = acc_ge ? div_rsp.quot[LW-1:0] + LW'(1) : div_rsp.quot[LW-1:0];
              last_seg_d = ps_eff == (cc_q - CCW'(1));
              state_d    = ST_PREP;
            end
          end
        end
      end
      ST_PREP: begin
        j_d = '0;
        if (len_q == LW'(1)) begin
          v_d     = cbs_pkg::V_HALF;
          state_d = ST_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = cbs_pkg::STEP_NUM;
          div_req.divisor  = CCW'({len_q - LW'(1), 1'b0});
          state_d          = ST_DIV_STEP;
        end
      end
      ST_DIV_STEP: begin
        if (div_rsp.done) begin
          dq_d    = div_rsp.quot[VW-1:0];
          dr_d    = div_rsp.rem[DDW-1:0];
          dd_d    = DDW'({len_q - LW'(1), 1'b0});
          vrem_d  = DDW'(len_q - LW'(1));
          v_d     = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (adv) begin
          tok_d.valid     = 1'b1;
          tok_d.seg_end   = seg_end;
          tok_d.curve_end = seg_end && last_seg_q;
          tok_v_d         = v_q;
          j_d             = j_q + LW'(1);
          v_d             = v_q + dq_q + VW'(vcarry);
          vrem_d          = vcarry ? DDW'(vsum - {1'b0, dd_q}) : vsum[DDW-1:0];
          if (j_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (adv) begin
          tok_d.valid = 1'b1;
          tok_d.err   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sc_q     <= cbs_pkg::SC_RESET;
      cc_q     <= cbs_pkg::CC_RESET;
      ps_q     <= '0;
      spread_q <= '0;
      tok_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
      end
      for (int i = 0; i < LAT; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ps_q     <= ps_d;
      spread_q <= spread_d;
      for (int i = 0; i < 3; i++) begin
        win_x_q[i] <= win_x_d[i];
        win_y_q[i] <= win_y_d[i];
      end
      if (cfg_we_i) begin
        unique case (cbs_pkg::cfg_idx_e'(cfg_index_i))
          cbs_pkg::CFG_SAMPLE_COUNT:  sc_q <= cfg_data_i;
          cbs_pkg::CFG_CONTROL_COUNT: cc_q <= cfg_data_i[CCW-1:0];
          default: ;
        endcase
      end
      if (adv) begin
        tok_q    <= tok_d;
        tag_q[0] <= tok_q;
        for (int i = 1; i < LAT; i++) begin
          tag_q[i] <= tag_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_seg_q <= last_seg_d;
    len_q      <= len_d;
    j_q        <= j_d;
    v_q        <= v_d;
    dq_q       <= dq_d;
    dr_q       <= dr_d;
    dd_q       <= dd_d;
    vrem_q     <= vrem_d;
    if (accept) begin
      px_q    <= point_x_i;
      py_q    <= point_y_i;
      first_q <= first_point_i;
    end
    if (cap) begin
      for (int i = 0; i < 3; i++) begin
        cx_q[i] <= win_x_q[i];
        cy_q[i] <= win_y_q[i];
      end
      cx_q[3] <= px_q;
      cy_q[3] <= py_q;
    end
    if (adv) begin
      tok_v_q <= tok_v_d;
    end
  end

  cbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cbs_basis u_basis (
    .clk_i (clk_i),
    .en_i  (adv),
    .v_i   (tok_v_q),
    .w_o   (w)
  );

  for (genvar gi = 0; gi < 4; gi++) begin : g_lane
    cbs_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_x (
      .clk_i  (clk_i),
      .en_i   (adv),
      .p_i    (cx_q[gi]),
      .w_i    (w[gi]),
      .term_o (term_x[gi])
    );
    cbs_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_y (
      .clk_i  (clk_i),
      .en_i   (adv),
      .p_i    (cy_q[gi]),
      .w_i    (w[gi]),
      .term_o (term_y[gi])
    );
  end

  cbs_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .term_i (term_x),
    .res_o  (res_x)
  );

  cbs_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .term_i (term_y),
    .res_o  (res_y)
  );

  assign sample_valid_o = tag_q[LAT-1].valid;
  assign sample_x_o     = tag_q[LAT-1].err ? '0 : res_x;
  assign sample_y_o     = tag_q[LAT-1].err ? '0 : res_y;
  assign segment_end_o  = tag_q[LAT-1].seg_end;
  assign curve_end_o    = tag_q[LAT-1].curve_end;
  assign config_error_o = tag_q[LAT-1].err;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic B-spline curve sampler.
// ----------------------------------------------------------------------------
// Control points are pushed through the point channel under several idle and
// stall mixes. A bit-exact model in the bench predicts every sample, and a
// checker compares each sample beat against the oldest prediction. Directed
// curves cover coordinate extremes, all count limits and the bad-count
// error path. Random curves, stray points and broken curves follow.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    bit          seg_end;
    bit          crv_end;
    bit          cfg_err;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [cbs_pkg::SCW-1:0] cfg_data_i;
  logic        point_valid_i;
  logic        point_stall_o;
  logic signed [31:0] point_x_i;
  logic signed [31:0] point_y_i;
  logic        first_point_i;
  logic        sample_valid_o;
  logic        sample_stall_i = 1'b0;
  logic signed [31:0] sample_x_o;
  logic signed [31:0] sample_y_o;
  logic        segment_end_o;
  logic        curve_end_o;
  logic        config_error_o;

  cubic_bspline_curve_sampler u_top (.*);

  always #10 clk_i = ~clk_i;

  sample_t     pending_samples[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  longint      cycle_no = 0;
  longint      hold_until = 0;

  // Bench copy of the sampler state.
  logic [cbs_pkg::SCW-1:0] m_sample_count;
  logic [cbs_pkg::CCW-1:0] m_control_count;
  logic [31:0]    win_x[3];
  logic [31:0]    win_y[3];
  logic [cbs_pkg::CCW-1:0] m_points_seen;
  logic [cbs_pkg::ACW-1:0] m_spread;

  function automatic logic [31:0] blend(logic [31:0] p[4], logic [127:0] w[4]);
    logic [127:0] acc;
    logic [127:0] t;
    acc = 128'd3 << 48;
    for (int i = 0; i < 4; i++) acc += {96'd0, p[i]} * w[i];
    t = (acc >> 48) / 6;
    if (t > 128'hFFFF_FFFF) t = 128'hFFFF_FFFF;
    return t[31:0] ^ 32'h8000_0000;
  endfunction

  function automatic bit counts_bad();
    int n, q, longest;
    if (m_sample_count < cbs_pkg::SC_MIN || m_control_count < cbs_pkg::CC_MIN ||
        m_control_count > cbs_pkg::CC_MAX)
      return 1;
    if (m_sample_count < m_control_count) return 1;
    n = m_control_count - 3;
    q = m_sample_count / n;
    longest = q + ((m_sample_count % n) != 0);
    return longest > cbs_pkg::MAXSEG_DEF;
  endfunction

  task automatic predict_point(logic [31:0] px_in, logic [31:0] py_in, bit first);
    logic [31:0]  px, py;
    logic [31:0]  cx[4], cy[4];
    logic [127:0] w[4];
    logic [127:0] v, u, v2, v3, s3;
    int n, q, r, acc, len;
    bit last_seg;
    sample_t s;
    px = px_in ^ 32'h8000_0000;
    py = py_in ^ 32'h8000_0000;
    if (counts_bad()) begin
      s = '{32'd0, 32'd0, 1'b0, 1'b0, 1'b1};
      pending_samples = {pending_samples, s};
      return;
    end
    if (first) begin
      win_x = '{32'd0, 32'd0, 32'd0};
      win_y = '{32'd0, 32'd0, 32'd0};
      m_points_seen = '0;
      m_spread = '0;
    end
    if (m_points_seen >= m_control_count) return;
    if (m_points_seen >= 3) begin
      n = m_control_count - 3;
      q = m_sample_count / n;
      r = m_sample_count % n;
      acc = m_spread + r;
      if (acc >= n) begin
        len = q + 1;
        acc -= n;
      end else begin
        len = q;
      end
      m_spread = acc[cbs_pkg::ACW-1:0];
      last_seg = (m_points_seen == m_control_count - 1);
      cx = '{win_x[0], win_x[1], win_x[2], px};
      cy = '{win_y[0], win_y[1], win_y[2], py};
      s3 = 128'd1 << 48;
      for (int j = 0; j < len && j < cbs_pkg::MAXSEG_DEF; j++) begin
        if (len == 1) v = 128'd32768;
        else v = (128'd2 * j * 65536 + (len - 1)) / (128'd2 * (len - 1));
        u = 128'd65536 - v;
        v2 = v * v;
        v3 = v2 * v;
        w[0] = u * u * u;
        w[1] = 3 * v3 + 4 * s3 - 6 * v2 * 65536;
        w[2] = 3 * v2 * 65536 + 3 * v * 65536 * 65536 + s3 - 3 * v3;
        w[3] = v3;
        s.x = blend(cx, w);
        s.y = blend(cy, w);
        s.seg_end = (j + 1 == len);
        s.crv_end = (j + 1 == len) && last_seg;
        s.cfg_err = 1'b0;
        pending_samples = {pending_samples, s};
      end
    end
    win_x = '{win_x[1], win_x[2], px};
    win_y = '{win_y[1], win_y[2], py};
    m_points_seen = m_points_seen + 1'b1;
  endtask

  // Sample checker.
  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && sample_valid_o && !sample_stall_i) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        $error("sample beat with no prediction: x=%h y=%h", sample_x_o, sample_y_o);
      end else begin
        e = pending_samples.pop_front();
        if (sample_x_o !== e.x) begin
          mismatches++;
          $error("sample_x expected %h got %h", e.x, sample_x_o);
        end
        if (sample_y_o !== e.y) begin
          mismatches++;
          $error("sample_y expected %h got %h", e.y, sample_y_o);
        end
        if (segment_end_o !== e.seg_end) begin
          mismatches++;
          $error("segment_end expected %0d got %0d", e.seg_end, segment_end_o);
        end
        if (curve_end_o !== e.crv_end) begin
          mismatches++;
          $error("curve_end expected %0d got %0d", e.crv_end, curve_end_o);
        end
        if (config_error_o !== e.cfg_err) begin
          mismatches++;
          $error("config_error expected %0d got %0d", e.cfg_err, config_error_o);
        end
      end
    end
  end

  // Receiver stall generator with its own cycle count for long holds.
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no < hold_until) sample_stall_i <= 1'b1;
    else sample_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_point(logic [31:0] px, logic [31:0] py, bit first);
    bit stalled;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      point_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    first_point_i <= first;
    do begin
      @(negedge clk_i);
      stalled = point_stall_o;
      @(posedge clk_i);
    end while (stalled);
    predict_point(px, py, first);
  endtask

  task automatic drain();
    point_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic set_counts(int sc, int cc);
    cfg_we_i <= 1'b1;
    cfg_index_i <= cbs_pkg::CFG_SAMPLE_COUNT;
    cfg_data_i <= sc[cbs_pkg::SCW-1:0];
    @(posedge clk_i);
    cfg_index_i <= cbs_pkg::CFG_CONTROL_COUNT;
    cfg_data_i <= cc[cbs_pkg::SCW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_sample_count = sc[cbs_pkg::SCW-1:0];
    m_control_count = cc[cbs_pkg::CCW-1:0];
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_curve(int pts);
    for (int i = 0; i < pts; i++) send_point(rand_coord(), rand_coord(), i == 0);
  endtask

  task automatic test_coordinate_extremes();
    logic [31:0] ext[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                            32'h0001_0000, 32'h5555_AAAA};
    for (int i = 0; i < 8; i++) send_point(ext[i % 6], ext[(i + 3) % 6], i == 0);
    send_point(32'h1234_5678, 32'h8765_4321, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    drain();
  endtask

  task automatic test_count_limits();
    set_counts(128, 5);
    send_curve(5);
    drain();
    set_counts(8, 8);
    send_curve(8);
    drain();
    set_counts(5, 5);
    send_curve(5);
    drain();
    set_counts(65535, 4096);
    send_curve(6);
    drain();
  endtask

  task automatic test_bad_counts();
    int bad[6][2] = '{'{4, 8}, '{65535, 5}, '{10, 12}, '{5000, 4097}, '{129, 5}, '{64, 4}};
    foreach (bad[i]) begin
      set_counts(bad[i][0], bad[i][1]);
      send_point(rand_coord(), rand_coord(), i % 2);
      drain();
    end
  endtask

  task automatic test_random_curves(int idle, int stall, int items);
    int sent, cc, n, pts;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      cc = $urandom_range(5, 12);
      n = cc - 3;
      set_counts($urandom_range(cc, n * 10), cc);
      repeat (3) begin
        case ($urandom_range(9))
          0: pts = $urandom_range(1, cc - 1);
          1: pts = cc + $urandom_range(1, 3);
          default: pts = cc;
        endcase
        send_curve(pts);
        sent += pts;
        if ($urandom_range(9) == 0) begin
          send_point(rand_coord(), rand_coord(), $urandom_range(1));
          sent++;
        end
      end
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_counts(128, 5);
    stall_pct = 20;
    hold_until = cycle_no + 3000;
    send_curve(5);
    send_curve(5);
    drain();
    stall_pct = 0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= cbs_pkg::CFG_SAMPLE_COUNT;
    cfg_data_i <= '0;
    point_valid_i <= 1'b0;
    point_x_i <= '0;
    point_y_i <= '0;
    first_point_i <= 1'b0;
    m_sample_count = cbs_pkg::SC_RESET;
    m_control_count = cbs_pkg::CC_RESET;
    win_x = '{32'd0, 32'd0, 32'd0};
    win_y = '{32'd0, 32'd0, 32'd0};
    m_points_seen = '0;
    m_spread = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_coordinate_extremes();
    test_count_limits();
    test_bad_counts();
    test_random_curves(0, 0, 125);
    test_random_curves(63, 0, 125);
    test_random_curves(0, 63, 125);
    test_random_curves(27, 27, 125);
    test_backpressure();
    drain();
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
